FILE: rtl/ptt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pulse transit time blood pressure estimator.
package ptt_pkg;

  localparam int RING_DEPTH = 5;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int TIME_W     = 32;
  localparam int TRANSIT_W  = 9;
  localparam int BP_W       = 8;
  localparam int CFG_IDX_W  = 2;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;

  localparam logic [TRANSIT_W-1:0] WINDOW_LOW_RST  = 9'd50;
  localparam logic [TRANSIT_W-1:0] WINDOW_HIGH_RST = 9'd500;

  // Breakpoints of the systolic map in ms.
  localparam logic [TRANSIT_W-1:0] T_KNEE_LOW  = 9'd150;
  localparam logic [TRANSIT_W-1:0] T_KNEE_MID  = 9'd250;
  localparam logic [TRANSIT_W-1:0] T_KNEE_HIGH = 9'd400;

  // Systolic levels in mmHg.
  localparam logic [8:0] SYS_TOP = 9'd180;
  localparam logic [8:0] SYS_MID = 9'd120;
  localparam logic [8:0] SYS_LOW = 9'd80;
  localparam logic [8:0] SYS_MAX = 9'd220;
  localparam logic [8:0] SYS_MIN = 9'd60;

  // Reciprocals for the constant divisions: x/5, x/15 and x/3 over the ranges used.
  localparam int MUL_A_W = 10;
  localparam int MUL_B_W = 11;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] RECIP_5  = 11'd205;
  localparam int                 SHIFT_5  = 10;
  localparam logic [MUL_B_W-1:0] RECIP_15 = 11'd1093;
  localparam int                 SHIFT_15 = 14;
  localparam logic [MUL_B_W-1:0] RECIP_3  = 11'd683;
  localparam int                 SHIFT_3  = 11;

  typedef struct packed {
    logic                 hit;
    logic [TRANSIT_W-1:0] data;
  } ring_status_t;

endpackage

FILE: rtl/ptt_blood_pressure_estimator.sv
`timescale 1ns / 1ps
// Top level: pairing of R-peaks and feet, window test, median search and pressure map.
//
//  channel   direction  payload
//  s_axis    in         tdata: rpeak_time, foot_time   tuser: rpeak_seen, foot_new
//  m_axis    out        tdata: transit_ms, systolic, diastolic   tuser: transit_valid
//  cfg       in         cfg_index, cfg_data (window_low, window_high)
//
// From acceptance to the raising of m_axis_tvalid the sequencer passes ST_CHECK and ST_FINISH;
// with a transit time it runs between them the median search, testing one ring entry
// per cycle, and, for a nonzero median, the shared multiplier for the slope and the diastolic ratio.
// s_axis_tready is high only while the sequencer is idle; a result waits in the output
// register while m_axis_tready is low, and the next request then holds in its last step.
// Synchronous reset clears the pairing timestamps and the ring count; cfg is always ready.
module ptt_blood_pressure_estimator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // rpeak_time[31:0], foot_time[63:32]
  input  logic [1:0]                    s_axis_tuser,  // rpeak_seen[0], foot_new[1]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // transit_ms[8:0], systolic[16:9],
                                                       // diastolic[24:17], zero[31:25]
  output logic [0:0]                    m_axis_tuser,  // transit_valid[0]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptt_pkg::TRANSIT_W-1:0] cfg_data
);
  import ptt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_RANK, ST_MAP, ST_SCALE, ST_DIA, ST_DIAQ, ST_FINISH
  } state_t;

  state_t               state;
  logic [TRANSIT_W-1:0] window_low;
  logic [TRANSIT_W-1:0] window_high;
  logic [TIME_W-1:0]    last_peak_time;
  logic [TIME_W-1:0]    last_foot_time;
  logic [TIME_W-1:0]    diff;
  logic                 try_flag;
  logic [SLOT_W-1:0]    cand;
  logic [TRANSIT_W-1:0] med;
  logic [BP_W-1:0]      sys;
  logic [BP_W-1:0]      dia;
  logic                 ok;
  logic                 seg_high;
  logic [PROD_W-1:0]    prod;

  logic                 rpeak_seen;
  logic                 foot_new;
  logic [TIME_W-1:0]    rpeak_time;
  logic [TIME_W-1:0]    foot_time;
  logic [TIME_W-1:0]    diff_next;
  logic                 try_next;
  logic                 in_window;
  logic                 ring_wr;
  ring_status_t         ring_status;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [TRANSIT_W-1:0] off_low;
  logic [TRANSIT_W-1:0] off_mid;
  logic [PROD_W-1:0]    quot;
  logic [8:0]           sys_raw;
  logic [8:0]           sys_clamped;

  assign rpeak_seen = s_axis_tuser[0];
  assign foot_new   = s_axis_tuser[1];
  assign rpeak_time = s_axis_tdata[31:0];
  assign foot_time  = s_axis_tdata[63:32];

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  assign in_window = try_flag && (diff[TIME_W-1:TRANSIT_W] == '0) &&
                     (diff[TRANSIT_W-1:0] >= window_low) &&
                     (diff[TRANSIT_W-1:0] <= window_high);
  assign ring_wr   = (state == ST_CHECK) && in_window;

  // Both flags pair the two new times; a new foot alone pairs with the remembered R-peak.
  always_comb begin
    diff_next = foot_time - rpeak_time;
    try_next  = 1'b0;
    if (rpeak_seen && foot_new) begin
      try_next = 1'b1;
    end else if (!rpeak_seen && foot_new && (foot_time != last_foot_time)) begin
      diff_next = foot_time - last_peak_time;
      try_next  = (last_peak_time != '0);
    end
  end

  ptt_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ring_wr),
    .wr_data (diff[TRANSIT_W-1:0]),
    .cand    (cand),
    .status  (ring_status)
  );

  // Operands of the shared multiplier: the slope segment in ST_MAP, two thirds in ST_DIA.
  always_comb begin
    off_low = med - T_KNEE_LOW;
    off_mid = med - T_KNEE_MID;
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      ST_MAP: begin
        if (med <= T_KNEE_MID) begin
          mul_a = {1'b0, off_low} + {off_low, 1'b0};
          mul_b = RECIP_5;
        end else begin
          mul_a = {off_mid[TRANSIT_W-2:0], 2'b00};
          mul_b = RECIP_15;
        end
      end
      ST_DIA: begin
        mul_a = MUL_A_W'({sys, 1'b0});
        mul_b = RECIP_3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    quot        = seg_high ? (prod >> SHIFT_15) : (prod >> SHIFT_5);
    sys_raw     = (seg_high ? SYS_MID : SYS_TOP) - quot[8:0];
    sys_clamped = sys_raw;
    if (sys_raw > SYS_MAX) begin
      sys_clamped = SYS_MAX;
    end
    if (sys_raw < SYS_MIN) begin
      sys_clamped = SYS_MIN;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      window_low     <= WINDOW_LOW_RST;
      window_high    <= WINDOW_HIGH_RST;
      last_peak_time <= '0;
      last_foot_time <= '0;
      m_axis_tvalid  <= 1'b0;
      try_flag       <= 1'b0;
      ok             <= 1'b0;
      cand           <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW_LOW:  window_low  <= cfg_data;
          REG_WINDOW_HIGH: window_high <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            try_flag <= try_next;
            diff     <= diff_next;
            if (rpeak_seen && !foot_new && (rpeak_time != last_peak_time)) begin
              last_peak_time <= rpeak_time;
            end
            if (!rpeak_seen && foot_new && (foot_time != last_foot_time)) begin
              last_foot_time <= foot_time;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cand <= '0;
          if (in_window) begin
            ok    <= 1'b1;
            state <= ST_RANK;
          end else begin
            ok    <= 1'b0;
            med   <= '0;
            sys   <= '0;
            dia   <= '0;
            state <= ST_FINISH;
          end
        end
        ST_RANK: begin
          if (ring_status.hit) begin
            med   <= ring_status.data;
            state <= ST_MAP;
          end else begin
            cand <= cand + 1'b1;
          end
        end
        ST_MAP: begin
          seg_high <= (med > T_KNEE_MID);
          if (med == '0) begin
            sys   <= '0;
            dia   <= '0;
            state <= ST_FINISH;
          end else if (med < T_KNEE_LOW) begin
            sys   <= SYS_TOP[BP_W-1:0];
            state <= ST_DIA;
          end else if (med > T_KNEE_HIGH) begin
            sys   <= SYS_LOW[BP_W-1:0];
            state <= ST_DIA;
          end else begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          sys   <= sys_clamped[BP_W-1:0];
          state <= ST_DIA;
        end
        ST_DIA: begin
          state <= ST_DIAQ;
        end
        ST_DIAQ: begin
          dia   <= prod[SHIFT_3 +: BP_W];
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, dia, sys, med};
            m_axis_tuser  <= ok;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/ptt_ring.sv
`timescale 1ns / 1ps
// Transit time ring with fill count and a rank test of one candidate entry.
module ptt_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ptt_pkg::TRANSIT_W-1:0] wr_data,
  input  logic [ptt_pkg::SLOT_W-1:0]    cand,
  output ptt_pkg::ring_status_t         status
);
  import ptt_pkg::*;

  logic [TRANSIT_W-1:0] ring [RING_DEPTH];
  logic [SLOT_W-1:0]    write_slot;
  logic [CNT_W-1:0]     fill_count;

  logic [TRANSIT_W-1:0] cand_data;
  logic [CNT_W-1:0]     less_cnt;
  logic [CNT_W-1:0]     leq_cnt;
  logic [CNT_W-1:0]     mid_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (wr_en) begin
      if (write_slot == SLOT_W'(RING_DEPTH - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
      if (fill_count != CNT_W'(RING_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[write_slot] <= wr_data;
    end
  end

  // The candidate is the median when its rank range covers the middle position.
  always_comb begin
    cand_data = ring[cand];
    less_cnt  = '0;
    leq_cnt   = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      if (CNT_W'(j) < fill_count) begin
        less_cnt = less_cnt + CNT_W'(ring[j] < cand_data);
        leq_cnt  = leq_cnt + CNT_W'(ring[j] <= cand_data);
      end
    end
    mid_rank    = fill_count >> 1;
    status.hit  = (less_cnt <= mid_rank) && (mid_rank < leq_cnt);
    status.data = cand_data;
  end

endmodule

FILE: rtl/ptt_checker.sv
`timescale 1ns / 1ps
// Port checker of the estimator and its bind to the top level.
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // One request at a time: the input side closes right after a request.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready again right after a request");

  // A result without an accepted transit time carries zeros only.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("nonzero payload on a result without transit time");

  // A nonzero systolic estimate lies inside the clamp range.
  a_sys_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[16:9] != 8'd0) |->
    (m_axis_tdata[16:9] >= 8'd60) && (m_axis_tdata[16:9] <= 8'd220))
    else $error("systolic estimate outside its clamp range");

  // A zero median gives no pressure estimate.
  a_zero_median: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[8:0] == 9'd0) |-> m_axis_tdata[24:9] == 16'd0)
    else $error("pressure estimate with a zero median");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind ptt_blood_pressure_estimator ptt_checker u_ptt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
